// ----- design/rds_group_generator_assert.svh -----
// Assertion macros used by the RDS group generator checker.
`ifndef RDS_GROUP_GENERATOR_ASSERT_SVH
`define RDS_GROUP_GENERATOR_ASSERT_SVH

// Same-cycle implication, checked at every rising clock edge outside reset
`define RGG_ASSERT_IMPL(label, clk, rstn, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("rds group generator: assertion failed");

// Next-cycle implication
`define RGG_ASSERT_NEXT(label, clk, rstn, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("rds group generator: assertion failed");

`endif

// ----- design/rgg_pkg.sv -----
`default_nettype none

package rgg_pkg;

  // Store depth default and fixed field widths
  localparam int TEXT_WORDS_DEF = 16;
  localparam int TEXT_IDX_W     = 4;
  localparam int TEXT_DATA_W    = 32;
  localparam int INFO_W         = 16;
  localparam int CHECK_W        = 10;
  localparam int BLK_NUM_W      = 2;
  localparam int CFG_IDX_W      = 2;
  localparam int CFG_DATA_W     = 64;
  localparam int SLOT_W         = 5;
  localparam int NAME_SEG_W     = 2;

  // Group cycle: name groups first, then text groups
  localparam logic [SLOT_W-1:0] CYCLE_SLOTS = 5'd20;
  localparam logic [SLOT_W-1:0] NAME_SLOTS  = 5'd4;

  // Fixed block contents
  localparam logic [INFO_W-1:0] GRP_0A_B = 16'h0400;
  localparam logic [INFO_W-1:0] GRP_2A_B = 16'h2400;
  localparam logic [INFO_W-1:0] TA_BIT   = 16'h0010;
  localparam logic [INFO_W-1:0] FILL_C   = 16'hCDCD;

  // Block positions
  localparam logic [BLK_NUM_W-1:0] BLK_A = 2'd0;
  localparam logic [BLK_NUM_W-1:0] BLK_D = 2'd3;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PROGRAM_ID   = 2'd0,
    CFG_TRAFFIC_ANN  = 2'd1,
    CFG_STATION_NAME = 2'd2
  } cfg_reg_e;

  // CRC generator x^10+x^8+x^7+x^5+x^4+x^3+1, low bits
  localparam logic [CHECK_W-1:0] CRC_POLY = 10'h1B9;

  // Offset words for blocks A..D
  localparam logic [CHECK_W-1:0] OFFSET_WORD [4] = '{10'h0FC, 10'h198, 10'h168, 10'h1B4};

  // Configuration write
  typedef struct packed {
    logic                  we;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;
  } cfg_wr_t;

  // Four information words of one group, block A at index 0
  typedef logic [3:0][INFO_W-1:0] grp_words_t;

  // One output block
  typedef struct packed {
    logic [BLK_NUM_W-1:0] num;
    logic [INFO_W-1:0]    info;
    logic [CHECK_W-1:0]   check;
    logic                 last;
  } blk_out_t;

  // Checkword of a single set information bit; used at elaboration only
  function automatic logic [CHECK_W-1:0] crc_col(int k);
    logic [CHECK_W-1:0] r;
    logic               din;
    logic               top;
    r = '0;
    for (int j = INFO_W - 1; j >= 0; j--) begin
      din = (j == k);
      top = r[CHECK_W-1];
      r   = {r[CHECK_W-2:0], 1'b0};
      if (din ^ top) r = r ^ CRC_POLY;
    end
    return r;
  endfunction

  localparam logic [CHECK_W-1:0] CRC_COLS [16] = '{
    crc_col(0),  crc_col(1),  crc_col(2),  crc_col(3),
    crc_col(4),  crc_col(5),  crc_col(6),  crc_col(7),
    crc_col(8),  crc_col(9),  crc_col(10), crc_col(11),
    crc_col(12), crc_col(13), crc_col(14), crc_col(15)
  };

  // Parallel CRC: XOR of the columns of the set bits
  function automatic logic [CHECK_W-1:0] crc10(logic [INFO_W-1:0] info);
    logic [CHECK_W-1:0] r;
    r = '0;
    for (int k = 0; k < INFO_W; k++) begin
      if (info[k]) r = r ^ CRC_COLS[k];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ----- design/rgg_group_builder.sv -----
`default_nettype none

// Holds configuration, group sequencing state and the radiotext store;
// assembles the four information words of the next group.
module rgg_group_builder
  import rgg_pkg::*;
#(
  parameter int TEXT_WORDS = TEXT_WORDS_DEF
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire cfg_wr_t                cfg_i,
  input  wire logic                   grp_req_i,
  input  wire logic                   text_we_i,
  input  wire logic [TEXT_IDX_W-1:0]  text_index_i,
  input  wire logic [TEXT_DATA_W-1:0] text_data_i,
  output grp_words_t                  grp_o
);

  localparam int SEG_W = (TEXT_WORDS > 1) ? $clog2(TEXT_WORDS) : 1;
  localparam logic [SEG_W-1:0] SEG_LAST = SEG_W'(TEXT_WORDS - 1);

  logic [INFO_W-1:0]      program_id_q;
  logic                   traffic_ann_q;
  logic [CFG_DATA_W-1:0]  station_name_q;
  logic [SLOT_W-1:0]      slot_q, slot_d;
  logic [NAME_SEG_W-1:0]  name_seg_q;
  logic [SEG_W-1:0]       text_seg_q, text_seg_d;
  logic [TEXT_DATA_W-1:0] store_q [TEXT_WORDS];

  logic                   is_name;
  logic [TEXT_DATA_W-1:0] text_word;
  logic [INFO_W-1:0]      ps_pair;
  logic                   idx_ok;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      program_id_q   <= '0;
      traffic_ann_q  <= 1'b0;
      station_name_q <= '0;
    end else if (cfg_i.we) begin
      case (cfg_i.index)
        CFG_PROGRAM_ID:   program_id_q   <= cfg_i.data[INFO_W-1:0];
        CFG_TRAFFIC_ANN:  traffic_ann_q  <= cfg_i.data[0];
        CFG_STATION_NAME: station_name_q <= cfg_i.data;
        default: ;
      endcase
    end
  end

  // Group content for the current slot
  always_comb begin
    is_name   = (slot_q < NAME_SLOTS);
    text_word = store_q[text_seg_q];
    ps_pair   = station_name_q[{~name_seg_q, 4'b0000} +: INFO_W];
    grp_o[0]  = program_id_q;
    if (is_name) begin
      grp_o[1] = GRP_0A_B | INFO_W'(name_seg_q) | (traffic_ann_q ? TA_BIT : '0);
      grp_o[2] = FILL_C;
      grp_o[3] = ps_pair;
    end else begin
      grp_o[1] = GRP_2A_B | INFO_W'(text_seg_q);
      grp_o[2] = text_word[TEXT_DATA_W-1:INFO_W];
      grp_o[3] = text_word[INFO_W-1:0];
    end
  end

  // Slot and text segment advance
  always_comb begin
    slot_d     = (slot_q == CYCLE_SLOTS - 5'd1) ? '0 : slot_q + 5'd1;
    text_seg_d = (text_seg_q == SEG_LAST) ? '0 : text_seg_q + SEG_W'(1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_q     <= '0;
      name_seg_q <= '0;
      text_seg_q <= '0;
    end else if (grp_req_i) begin
      slot_q <= slot_d;
      if (is_name) name_seg_q <= name_seg_q + 2'd1;
      else         text_seg_q <= text_seg_d;
    end
  end

  // Radiotext store, cleared at reset; out-of-range writes dropped
  assign idx_ok = (32'(text_index_i) < TEXT_WORDS);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < TEXT_WORDS; i++) store_q[i] <= '0;
    end else if (text_we_i && idx_ok) begin
      store_q[text_index_i[SEG_W-1:0]] <= text_data_i;
    end
  end

endmodule

`default_nettype wire

// ----- design/rgg_block_serializer.sv -----
`default_nettype none

// Buffers one group and sends its four blocks, checkword attached,
// through an output register.
module rgg_block_serializer
  import rgg_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       load_i,
  input  wire grp_words_t grp_i,
  output logic            can_load_o,
  output logic            valid_o,
  input  wire logic       ready_i,
  output blk_out_t        blk_o
);

  grp_words_t           grp_q;
  logic                 grp_valid_q, grp_valid_d;
  logic [BLK_NUM_W-1:0] cnt_q, cnt_d;
  logic                 valid_q, valid_d;
  blk_out_t             blk_q, blk_d;
  logic                 out_free;
  logic                 advance;

  assign out_free   = !valid_q || ready_i;
  assign advance    = grp_valid_q && out_free;
  assign can_load_o = !grp_valid_q || (advance && (cnt_q == BLK_D));

  // Next block into the output register
  always_comb begin
    blk_d.num   = cnt_q;
    blk_d.info  = grp_q[cnt_q];
    blk_d.check = crc10(grp_q[cnt_q]) ^ OFFSET_WORD[cnt_q];
    blk_d.last  = (cnt_q == BLK_D);
  end

  // Buffer occupancy, block counter and output valid
  always_comb begin
    grp_valid_d = grp_valid_q;
    cnt_d       = cnt_q;
    if (advance) begin
      cnt_d = cnt_q + 2'd1;
      if (cnt_q == BLK_D) grp_valid_d = 1'b0;
    end
    if (load_i) begin
      grp_valid_d = 1'b1;
      cnt_d       = BLK_A;
    end
    valid_d = out_free ? grp_valid_q : valid_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      grp_valid_q <= 1'b0;
      cnt_q       <= BLK_A;
      valid_q     <= 1'b0;
    end else begin
      grp_valid_q <= grp_valid_d;
      cnt_q       <= cnt_d;
      valid_q     <= valid_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (load_i)  grp_q <= grp_i;
    if (advance) blk_q <= blk_d;
  end

  assign valid_o = valid_q;
  assign blk_o   = blk_q;

endmodule

`default_nettype wire

// ----- design/rds_group_generator.sv -----
// Channel   | Dir | Word                                   | Side info
// s_axis    | in  | tdata: text_index[3:0], text_data[35:4] | tuser: cmd
// m_axis    | out | tdata: block_number[1:0], info_word     | tlast: last_block
//           |     |   [17:2], check_word[27:18]            |
// cfg       | in  | cfg_data_i written to cfg_index_i       | cfg_we_i
//
// A group request sends four blocks on the output side, one block per cycle while m_axis is ready;
// the next request is taken in the cycle block D leaves the group buffer.
// A text write is accepted whenever the group buffer can load.
// After the request is accepted, block A reaches m_axis through the
// group buffer, then the output register.
// Reset clears all control state, the configuration and the radiotext store.
// m_axis stalls hold the block in the output register and back-pressure s_axis while a group is buffered.
`default_nettype none

module rds_group_generator
  import rgg_pkg::*;
#(
  parameter int TEXT_WORDS = TEXT_WORDS_DEF
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  // config write port
  input  wire logic                  cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_data_i,
  // input words
  input  wire logic                  s_axis_tvalid,
  output logic                       s_axis_tready,
  input  wire logic [39:0]           s_axis_tdata,  // text_index[3:0], text_data[35:4]
  input  wire logic                  s_axis_tuser,  // cmd
  // output blocks
  output logic                       m_axis_tvalid,
  input  wire logic                  m_axis_tready,
  output logic [31:0]                m_axis_tdata,  // block_number, info_word, check_word
  output logic                       m_axis_tlast   // last_block
);

  cfg_wr_t    cfg;
  grp_words_t grp;
  blk_out_t   blk;
  logic       accept;
  logic       grp_req;
  logic       text_we;
  logic       can_load;

  assign cfg.we    = cfg_we_i;
  assign cfg.index = cfg_index_i;
  assign cfg.data  = cfg_data_i;

  // Input handshake and command decode
  assign s_axis_tready = can_load;
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign grp_req       = accept && !s_axis_tuser;
  assign text_we       = accept && s_axis_tuser;

  rgg_group_builder #(
    .TEXT_WORDS(TEXT_WORDS)
  ) u_builder (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .grp_req_i   (grp_req),
    .text_we_i   (text_we),
    .text_index_i(s_axis_tdata[TEXT_IDX_W-1:0]),
    .text_data_i (s_axis_tdata[TEXT_IDX_W +: TEXT_DATA_W]),
    .grp_o       (grp)
  );

  rgg_block_serializer u_serializer (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .load_i    (grp_req),
    .grp_i     (grp),
    .can_load_o(can_load),
    .valid_o   (m_axis_tvalid),
    .ready_i   (m_axis_tready),
    .blk_o     (blk)
  );

  // Output word packing
  assign m_axis_tdata = {4'b0000, blk.check, blk.info, blk.num};
  assign m_axis_tlast = blk.last;

endmodule

`default_nettype wire

// ----- design/rgg_checker.sv -----
`default_nettype none

`include "rds_group_generator_assert.svh"

// Port-level checks on the RDS group generator
module rgg_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        s_axis_tready,
  input wire logic        m_axis_tvalid,
  input wire logic        m_axis_tready,
  input wire logic [31:0] m_axis_tdata,
  input wire logic        m_axis_tlast
);

  // tlast marks block D and nothing else
  `RGG_ASSERT_IMPL(a_last_on_d, clk_i, rst_ni, m_axis_tvalid, m_axis_tlast == (m_axis_tdata[1:0] == 2'd3))

  // Blocks of a group follow back to back, in order
  `RGG_ASSERT_NEXT(a_blk_order, clk_i, rst_ni, m_axis_tvalid && m_axis_tready && !m_axis_tlast, m_axis_tvalid && (m_axis_tdata[1:0] == $past(m_axis_tdata[1:0]) + 2'd1))

  // Mid-group stall keeps the input closed
  `RGG_ASSERT_IMPL(a_busy_stall, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready && !m_axis_tlast, !s_axis_tready)

  // Stalled word holds
  `RGG_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata))

endmodule

bind rds_group_generator rgg_checker u_checker (.*);

`default_nettype wire
